/* rtl/core/fdraw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdraw_pkg
// Shared types, constants and helpers of the framebuffer draw engine.
// ----------------------------------------------------------------------------
package fdraw_pkg;

  localparam int FRAME_WIDTH  = 160;
  localparam int FRAME_HEIGHT = 160;
  localparam int PIXELS       = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW           = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int XW           = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int YW           = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
  // root operand: square of an 11-bit magnitude
  localparam int SQW          = 22;

  localparam logic [3:0] KIND_FILL      = 4'd0;
  localparam logic [3:0] KIND_PIXEL     = 4'd1;
  localparam logic [3:0] KIND_HRUN      = 4'd2;
  localparam logic [3:0] KIND_VRUN      = 4'd3;
  localparam logic [3:0] KIND_LINE      = 4'd4;
  localparam logic [3:0] KIND_RECT      = 4'd5;
  localparam logic [3:0] KIND_FILLRECT  = 4'd6;
  localparam logic [3:0] KIND_CIRCLE    = 4'd7;
  localparam logic [3:0] KIND_FILLCIRC  = 4'd8;
  localparam logic [3:0] KIND_READ      = 4'd9;

  typedef logic signed [14:0] coord_t;
  typedef logic signed [16:0] err_t;

  localparam coord_t C_ZERO = coord_t'(0);
  localparam coord_t C_ONE  = coord_t'(1);

  typedef enum logic [3:0] {
    OP_FILL, OP_PIXEL, OP_HRUN, OP_VRUN, OP_LINE, OP_RECT,
    OP_FILLRECT, OP_CIRCLE, OP_FILLCIRC, OP_READ, OP_NONE
  } op_e;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [11:0] x_pos;
    logic signed [11:0] y_pos;
    logic signed [11:0] second_x;
    logic signed [11:0] second_y;
    logic signed [11:0] radius;
    logic [15:0]        color;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_color;
    logic        read_inside;
  } out_item_t;

  typedef struct packed {
    op_e                op;
    logic signed [11:0] x_pos;
    logic signed [11:0] y_pos;
    logic signed [11:0] second_x;
    logic signed [11:0] second_y;
    logic signed [11:0] radius;
    logic [15:0]        color;
  } cmd_t;

  // back to front: take the head command, clearing pass in progress
  typedef struct packed {
    logic take;
    logic clearing;
  } bk_stat_t;

  typedef struct packed {
    logic   active;
    logic   horz;
    coord_t fix;
    coord_t cur;
    coord_t stop;
  } span_t;

  typedef struct packed {
    logic          valid;
    logic          rd;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic [15:0]   color;
  } px_t;

  function automatic logic in_frame(coord_t x, coord_t y);
    return (x >= C_ZERO) && (x < coord_t'(FRAME_WIDTH)) &&
           (y >= C_ZERO) && (y < coord_t'(FRAME_HEIGHT));
  endfunction

  // Clip a run to the frame; inactive when nothing of it is visible.
  function automatic span_t span_setup(logic horz, coord_t x, coord_t y, coord_t len);
    span_t  s;
    coord_t st;
    coord_t along;
    coord_t across;
    coord_t hi;
    st     = horz ? x : y;
    along  = horz ? coord_t'(FRAME_WIDTH) : coord_t'(FRAME_HEIGHT);
    across = horz ? coord_t'(FRAME_HEIGHT) : coord_t'(FRAME_WIDTH);
    hi     = st + len;
    if (hi > along) hi = along;
    s.horz   = horz;
    s.fix    = horz ? y : x;
    s.cur    = (st < C_ZERO) ? C_ZERO : st;
    s.stop   = hi;
    s.active = (len > C_ZERO) && (s.fix >= C_ZERO) && (s.fix < across) && (s.cur < hi);
    return s;
  endfunction

endpackage

/* rtl/core/fdraw_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdraw_front
// Accept items, classify the kind, hold them in a two-entry command queue.
// ----------------------------------------------------------------------------
module fdraw_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  fdraw_pkg::in_item_t in_item_i,
  output logic                cmd_valid_o,
  output fdraw_pkg::cmd_t     cmd_o,
  input  fdraw_pkg::bk_stat_t stat_i
);
  import fdraw_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       acc, deq;
  cmd_t       cls;

  always_comb begin
    cls.x_pos    = in_item_i.x_pos;
    cls.y_pos    = in_item_i.y_pos;
    cls.second_x = in_item_i.second_x;
    cls.second_y = in_item_i.second_y;
    cls.radius   = in_item_i.radius;
    cls.color    = in_item_i.color;
    unique case (in_item_i.kind)
      KIND_FILL:     cls.op = OP_FILL;
      KIND_PIXEL:    cls.op = OP_PIXEL;
      KIND_HRUN:     cls.op = OP_HRUN;
      KIND_VRUN:     cls.op = OP_VRUN;
      KIND_LINE:     cls.op = OP_LINE;
      KIND_RECT:     cls.op = OP_RECT;
      KIND_FILLRECT: cls.op = OP_FILLRECT;
      KIND_CIRCLE:   cls.op = OP_CIRCLE;
      KIND_FILLCIRC: cls.op = OP_FILLCIRC;
      KIND_READ:     cls.op = OP_READ;
      default:       cls.op = OP_NONE;
    endcase
  end

  assign full        = (cnt_q == 2'd2) || stat_i.clearing;
  assign acc         = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign deq         = cmd_valid_o && stat_i.take;
  assign cmd_o       = slot_q[rd_q];

  always_comb begin
    wr_d  = acc ? !wr_q : wr_q;
    rd_d  = deq ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, acc} - {1'b0, deq};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) slot_q[wr_q] <= cls;
  end

endmodule

/* rtl/core/fdraw_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdraw_back
// Rasterize one command at a time into the frame store, one pixel per cycle.
// ----------------------------------------------------------------------------
module fdraw_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  fdraw_pkg::cmd_t      cmd_i,
  output fdraw_pkg::bk_stat_t  stat_o,
  input  logic                 res_full_i,
  output logic                 res_push_o,
  output fdraw_pkg::out_item_t res_o
);
  import fdraw_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SPANS, S_SQRT, S_LINE, S_CIRC, S_RWAIT} state_e;

  state_e          state_q, state_d;
  cmd_t            cmd_q, cmd_d;
  logic            clr_q, clr_d;
  coord_t          k_q, k_d, last_q, last_d;
  span_t           sp_q, sp_d;
  coord_t          lx_q, lx_d, ly_q, ly_d, ldx_q, ldx_d, ldy_q, ldy_d;
  logic            lnx_q, lnx_d, lny_q, lny_d;
  err_t            err_q, err_d;
  coord_t          ca_q, ca_d, cb_q, cb_d;
  logic [2:0]      ph_q, ph_d;
  logic [SQW-1:0]  rr_q, rr_d, sv_q, sv_d, sres_q, sres_d, sbit_q, sbit_d;
  px_t             px_q, px_d;
  logic            rdone_q;
  logic [15:0]     rdata_q;
  logic [15:0]     mem [PIXELS];
  logic [AW-1:0]   addr;

  coord_t          cx, cy, csx, csy, cr, px, py, b1, a1, hw;
  err_t            e2, e1, t1;
  logic signed [23:0] sq24;
  logic [SQW-1:0]  trial;
  logic [10:0]     sroot;

  assign cx  = coord_t'(cmd_q.x_pos);
  assign cy  = coord_t'(cmd_q.y_pos);
  assign csx = coord_t'(cmd_q.second_x);
  assign csy = coord_t'(cmd_q.second_y);
  assign cr  = coord_t'(cmd_q.radius);

  assign stat_o.take     = (state_q == S_IDLE) && !res_full_i;
  assign stat_o.clearing = clr_q;

  always_comb begin
    state_d = state_q; cmd_d = cmd_q; clr_d = clr_q; k_d = k_q; last_d = last_q;
    sp_d = sp_q; lx_d = lx_q; ly_d = ly_q; ldx_d = ldx_q; ldy_d = ldy_q;
    lnx_d = lnx_q; lny_d = lny_q; err_d = err_q; ca_d = ca_q; cb_d = cb_q;
    ph_d = ph_q; rr_d = rr_q; sv_d = sv_q; sres_d = sres_q; sbit_d = sbit_q;
    px_d = '0; px_d.color = cmd_q.color;
    res_push_o = 1'b0; res_o = '0;
    px = C_ZERO; py = C_ZERO; e2 = '0; e1 = '0; t1 = '0; b1 = C_ZERO; a1 = C_ZERO;
    hw = C_ZERO; sq24 = '0; trial = '0; sroot = '0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && !res_full_i) begin
          cmd_d = cmd_i;
          k_d   = C_ZERO;
          unique case (cmd_i.op)
            OP_FILL: begin
              last_d = coord_t'(FRAME_HEIGHT); state_d = S_SPANS;
            end
            OP_PIXEL, OP_HRUN, OP_VRUN: begin
              last_d = C_ONE; state_d = S_SPANS;
            end
            OP_RECT: begin
              last_d = coord_t'(4); state_d = S_SPANS;
            end
            OP_FILLRECT: begin
              last_d  = (cmd_i.second_y > 0) ? coord_t'(cmd_i.second_y) : C_ZERO;
              state_d = S_SPANS;
            end
            OP_FILLCIRC: begin
              sq24 = cmd_i.radius * cmd_i.radius;
              rr_d = sq24[SQW-1:0];
              if (cmd_i.radius < 0) begin
                last_d = C_ZERO;
              end else begin
                k_d    = -coord_t'(cmd_i.radius);
                last_d = coord_t'(cmd_i.radius) + C_ONE;
              end
              state_d = S_SPANS;
            end
            OP_LINE: begin
              lx_d  = coord_t'(cmd_i.x_pos);
              ly_d  = coord_t'(cmd_i.y_pos);
              lnx_d = !(cmd_i.x_pos < cmd_i.second_x);
              lny_d = !(cmd_i.y_pos < cmd_i.second_y);
              ldx_d = (cmd_i.second_x > cmd_i.x_pos)
                    ? coord_t'(cmd_i.second_x) - coord_t'(cmd_i.x_pos)
                    : coord_t'(cmd_i.x_pos) - coord_t'(cmd_i.second_x);
              ldy_d = (cmd_i.second_y > cmd_i.y_pos)
                    ? coord_t'(cmd_i.second_y) - coord_t'(cmd_i.y_pos)
                    : coord_t'(cmd_i.y_pos) - coord_t'(cmd_i.second_y);
              err_d   = err_t'(ldx_d) - err_t'(ldy_d);
              state_d = S_LINE;
            end
            OP_CIRCLE: begin
              ca_d = coord_t'(cmd_i.radius); cb_d = C_ZERO; err_d = '0; ph_d = '0;
              state_d = S_CIRC;
            end
            OP_READ: begin
              if (in_frame(coord_t'(cmd_i.x_pos), coord_t'(cmd_i.y_pos))) begin
                px_d.valid = 1'b1;
                px_d.rd    = 1'b1;
                px_d.x     = cmd_i.x_pos[XW-1:0];
                px_d.y     = cmd_i.y_pos[YW-1:0];
                state_d    = S_RWAIT;
              end else begin
                res_push_o = 1'b1;
              end
            end
            default: res_push_o = 1'b1;
          endcase
        end
      end
      S_SPANS: begin
        if (sp_q.active) begin
          px_d.valid = 1'b1;
          px_d.x = sp_q.horz ? sp_q.cur[XW-1:0] : sp_q.fix[XW-1:0];
          px_d.y = sp_q.horz ? sp_q.fix[YW-1:0] : sp_q.cur[YW-1:0];
          sp_d.cur = sp_q.cur + C_ONE;
          if (sp_q.cur + C_ONE == sp_q.stop) sp_d.active = 1'b0;
        end else if (k_q == last_q) begin
          // drop the result of the reset clearing pass
          if (clr_q) clr_d = 1'b0;
          else res_push_o = 1'b1;
          state_d = S_IDLE;
        end else begin
          k_d = k_q + C_ONE;
          case (cmd_q.op)
            OP_FILL:     sp_d = span_setup(1'b1, C_ZERO, k_q, coord_t'(FRAME_WIDTH));
            OP_PIXEL:    sp_d = span_setup(1'b1, cx, cy, C_ONE);
            OP_HRUN:     sp_d = span_setup(1'b1, cx, cy, csx);
            OP_VRUN:     sp_d = span_setup(1'b0, cx, cy, csy);
            OP_FILLRECT: sp_d = span_setup(1'b1, cx, cy + k_q, csx);
            OP_RECT: begin
              if (k_q == C_ZERO)              sp_d = span_setup(1'b1, cx, cy, csx);
              else if (k_q == C_ONE)          sp_d = span_setup(1'b1, cx, cy + csy - C_ONE, csx);
              else if (k_q == coord_t'(2))    sp_d = span_setup(1'b0, cx, cy, csy);
              else                            sp_d = span_setup(1'b0, cx + csx - C_ONE, cy, csy);
            end
            OP_FILLCIRC: begin
              // hold k for the row; start the root of r*r - dy*dy
              k_d    = k_q;
              sq24   = $signed(k_q[11:0]) * $signed(k_q[11:0]);
              sv_d   = rr_q - sq24[SQW-1:0];
              sres_d = '0;
              sbit_d = SQW'(1) << (SQW - 2);
              state_d = S_SQRT;
            end
            default: sp_d.active = 1'b0;
          endcase
        end
      end
      S_SQRT: begin
        if (sbit_q != '0) begin
          trial = sres_q + sbit_q;
          if (sv_q >= trial) begin
            sv_d   = sv_q - trial;
            sres_d = (sres_q >> 1) + sbit_q;
          end else begin
            sres_d = sres_q >> 1;
          end
          sbit_d = sbit_q >> 2;
        end else begin
          // round half up: remainder above the root adds one
          sroot = sres_q[10:0];
          hw    = coord_t'(sroot) + ((sv_q > SQW'(sroot)) ? C_ONE : C_ZERO);
          sp_d  = span_setup(1'b1, cx - hw, cy + k_q, hw + hw + C_ONE);
          k_d   = k_q + C_ONE;
          state_d = S_SPANS;
        end
      end
      S_LINE: begin
        px_d.valid = in_frame(lx_q, ly_q);
        px_d.x     = lx_q[XW-1:0];
        px_d.y     = ly_q[YW-1:0];
        if (lx_q == csx && ly_q == csy) begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end else begin
          e2 = err_q <<< 1;
          if (e2 > -err_t'(ldy_q)) begin
            err_d = err_d - err_t'(ldy_q);
            lx_d  = lnx_q ? lx_q - C_ONE : lx_q + C_ONE;
          end
          if (e2 < err_t'(ldx_q)) begin
            err_d = err_d + err_t'(ldx_q);
            ly_d  = lny_q ? ly_q - C_ONE : ly_q + C_ONE;
          end
        end
      end
      S_CIRC: begin
        case (ph_q)
          3'd0:    begin px = cx + ca_q; py = cy + cb_q; end
          3'd1:    begin px = cx + cb_q; py = cy + ca_q; end
          3'd2:    begin px = cx - cb_q; py = cy + ca_q; end
          3'd3:    begin px = cx - ca_q; py = cy + cb_q; end
          3'd4:    begin px = cx - ca_q; py = cy - cb_q; end
          3'd5:    begin px = cx - cb_q; py = cy - ca_q; end
          3'd6:    begin px = cx + cb_q; py = cy - ca_q; end
          default: begin px = cx + ca_q; py = cy - cb_q; end
        endcase
        px_d.valid = in_frame(px, py);
        px_d.x     = px[XW-1:0];
        px_d.y     = py[YW-1:0];
        ph_d       = ph_q + 3'd1;
        if (ph_q == 3'd7) begin
          if (ca_q > cb_q) begin
            b1 = cb_q + C_ONE;
            e1 = err_q + err_t'(1) + (err_t'(b1) <<< 1);
            t1 = e1 - (err_t'(ca_q) <<< 1) - err_t'(1);
            if (t1 > err_t'(0)) begin
              a1   = ca_q - C_ONE;
              e1   = e1 + err_t'(1) - (err_t'(a1) <<< 1);
              ca_d = a1;
            end
            cb_d  = b1;
            err_d = e1;
          end else begin
            res_push_o = 1'b1;
            state_d    = S_IDLE;
          end
        end
      end
      S_RWAIT: begin
        if (rdone_q) begin
          res_push_o        = 1'b1;
          res_o.read_color  = rdata_q;
          res_o.read_inside = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // come out of reset sweeping the frame with color zero
      state_q <= S_SPANS;
      cmd_q   <= '0;
      clr_q   <= 1'b1;
      k_q     <= C_ZERO;
      last_q  <= coord_t'(FRAME_HEIGHT);
      sp_q    <= '0;
      px_q    <= '0;
      rdone_q <= 1'b0;
      lx_q <= C_ZERO; ly_q <= C_ZERO; ldx_q <= C_ZERO; ldy_q <= C_ZERO;
      lnx_q <= 1'b0; lny_q <= 1'b0; err_q <= '0;
      ca_q <= C_ZERO; cb_q <= C_ZERO; ph_q <= '0;
      rr_q <= '0; sv_q <= '0; sres_q <= '0; sbit_q <= '0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      clr_q   <= clr_d;
      k_q     <= k_d;
      last_q  <= last_d;
      sp_q    <= sp_d;
      px_q    <= px_d;
      rdone_q <= px_q.valid && px_q.rd;
      lx_q <= lx_d; ly_q <= ly_d; ldx_q <= ldx_d; ldy_q <= ldy_d;
      lnx_q <= lnx_d; lny_q <= lny_d; err_q <= err_d;
      ca_q <= ca_d; cb_q <= cb_d; ph_q <= ph_d;
      rr_q <= rr_d; sv_q <= sv_d; sres_q <= sres_d; sbit_q <= sbit_d;
    end
  end

  assign addr = AW'(px_q.y) * AW'(FRAME_WIDTH) + AW'(px_q.x);

  always_ff @(posedge clk_i) begin
    if (px_q.valid && !px_q.rd) mem[addr] <= px_q.color;
    if (px_q.valid && px_q.rd) rdata_q <= mem[addr];
  end

endmodule

/* rtl/core/fdraw_outq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdraw_outq
// Two-entry result queue in front of the result port.
// ----------------------------------------------------------------------------
module fdraw_outq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 res_push_i,
  input  fdraw_pkg::out_item_t res_i,
  output logic                 res_full_o,
  output logic                 empty,
  input  logic                 pop,
  output fdraw_pkg::out_item_t out_item_o
);
  import fdraw_pkg::*;

  out_item_t  slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       deq;

  assign empty      = (cnt_q == 2'd0);
  assign res_full_o = (cnt_q == 2'd2);
  assign deq        = pop && !empty;
  assign out_item_o = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (res_push_i) wr_q <= !wr_q;
      if (deq) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, res_push_i} - {1'b0, deq};
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push_i) slot_q[wr_q] <= res_i;
  end

endmodule

/* rtl/core/framebuffer_draw_engine_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_draw_engine_top
// 2D rasterizer over a 160x160 RGB565 frame store with a pixel readout.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive in_item_i and push; an item is taken on a clock edge
//   with push high and full low. Result queue: while empty is low the oldest
//   result sits on out_item_o; pop takes it. Every command gives exactly one
//   result: a read returns the stored pixel and read_inside, all else zeros.
//   The front holds up to two classified commands, so the sender keeps going
//   while the rasterizer works; the back draws one command at a time.
//   Throughput: one pixel write per cycle over the clipped shape, plus a
//   setup step per run (rect has four runs, fill rect one per row, fill all
//   one per frame row). Lines write one pixel per Bresenham step, circles
//   eight points per octant step, and filled circles work out an integer
//   root per row before the row itself. A read's result passes the pixel
//   register and the store's read register before it enters the result queue.
//   Reset: the store is swept to zero; full stays high until the sweep ends.
//   A stalled receiver fills the two-entry result queue; the back then holds
//   off new commands and the input queue fills behind it.
// ----------------------------------------------------------------------------
module framebuffer_draw_engine_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  fdraw_pkg::in_item_t  in_item_i,
  output logic                 empty,
  input  logic                 pop,
  output fdraw_pkg::out_item_t out_item_o
);
  import fdraw_pkg::*;

  logic      cmd_valid;
  cmd_t      cmd;
  bk_stat_t  stat;
  logic      res_full;
  logic      res_push;
  out_item_t res;

  // classify and queue commands
  fdraw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // rasterize into the frame store
  fdraw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  // hold results for the receiver
  fdraw_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res),
    .res_full_o (res_full),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

/* rtl/core/fdraw_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdraw_chk
// Port-level checks of the draw engine, bound to the top level.
// ----------------------------------------------------------------------------
module fdraw_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 push,
  input logic                 full,
  input fdraw_pkg::in_item_t  in_item_i,
  input logic                 empty,
  input logic                 pop,
  input fdraw_pkg::out_item_t out_item_o
);
  import fdraw_pkg::*;

  // the clearing sweep holds off items right after reset
  a_clear_blocks: assert property (@(posedge clk_i) $rose(rst_ni) |-> full)
    else $error("item accepted during clearing sweep");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_item_o))
    else $error("result changed while stalled");

  // only an in-frame read carries a color
  a_color_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !out_item_o.read_inside |-> out_item_o.read_color == 16'd0)
    else $error("color on a result without a read");

  // no result can be waiting before any item has been taken
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> empty)
    else $error("result present out of reset");

endmodule

bind framebuffer_draw_engine_top fdraw_chk u_chk (.*);

/* dv/framebuffer_draw_engine_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_draw_engine_top_test
// Self-checking bench for the draw engine. A frame mirror in the bench
// replays every accepted command. Read commands compare the stored pixel
// against the mirror; every other command must return an all-zero item.
// ----------------------------------------------------------------------------
module framebuffer_draw_engine_top_test;
  import fdraw_pkg::*;

  localparam int RANDOM_ITEMS = 1200;
  localparam int CALM_TAIL    = 200;
  localparam int CYCLE_LIMIT  = 20000000;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop;
  out_item_t out_item;

  framebuffer_draw_engine_top u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item)
  );

  // Mirror of the frame store and the results it predicts, oldest first.
  logic [15:0] frame_mirror [PIXELS];
  out_item_t   expected_results [$];
  in_item_t    pending_cmds [$];

  int  failures;
  int  accepted;
  int  checked;
  int  reads_inside;
  int  total_planned;
  int  send_gap;
  int  take_gap;
  int  cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void plot(int x, int y, logic [15:0] c);
    if (x < 0 || x >= FRAME_WIDTH || y < 0 || y >= FRAME_HEIGHT) return;
    frame_mirror[y * FRAME_WIDTH + x] = c;
  endfunction

  function automatic void draw_hrun(int x, int y, int w, logic [15:0] c);
    if (w <= 0) return;
    for (int i = 0; i < w && x + i < FRAME_WIDTH; i++) plot(x + i, y, c);
  endfunction

  function automatic void draw_vrun(int x, int y, int h, logic [15:0] c);
    if (h <= 0) return;
    for (int i = 0; i < h && y + i < FRAME_HEIGHT; i++) plot(x, y + i, c);
  endfunction

  function automatic void draw_line(int x0, int y0, int x1, int y1, logic [15:0] c);
    int dx;
    int dy;
    int sx;
    int sy;
    int err;
    int e2;
    dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy  = (y1 > y0) ? y1 - y0 : y0 - y1;
    sx  = (x0 < x1) ? 1 : -1;
    sy  = (y0 < y1) ? 1 : -1;
    err = dx - dy;
    forever begin
      plot(x0, y0, c);
      if (x0 == x1 && y0 == y1) break;
      e2 = 2 * err;
      if (e2 > -dy) begin
        err -= dy;
        x0 += sx;
      end
      if (e2 < dx) begin
        err += dx;
        y0 += sy;
      end
    end
  endfunction

  function automatic void plot_octants(int cx, int cy, int a, int b, logic [15:0] c);
    plot(cx + a, cy + b, c);
    plot(cx + b, cy + a, c);
    plot(cx - b, cy + a, c);
    plot(cx - a, cy + b, c);
    plot(cx - a, cy - b, c);
    plot(cx - b, cy - a, c);
    plot(cx + b, cy - a, c);
    plot(cx + a, cy - b, c);
  endfunction

  function automatic void draw_circle(int cx, int cy, int r, logic [15:0] c);
    int x;
    int y;
    int err;
    x   = r;
    y   = 0;
    err = 0;
    plot_octants(cx, cy, x, y, c);
    while (x > y) begin
      y++;
      err += 1 + 2 * y;
      if (err + 2 * (-x - 1) + 1 > 0) begin
        x--;
        err += 1 - 2 * x;
      end
      plot_octants(cx, cy, x, y, c);
    end
  endfunction

  function automatic int unsigned int_root(int unsigned v);
    int unsigned res;
    int unsigned b;
    res = 0;
    b   = 32'h4000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v  -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void draw_disc(int cx, int cy, int r, logic [15:0] c);
    int unsigned w2;
    int unsigned s;
    int          hw;
    if (r < 0) return;
    for (int dy = -r; dy <= r; dy++) begin
      w2 = r * r - dy * dy;
      s  = int_root(w2);
      // round the half width half up
      hw = s + ((w2 > s * s + s) ? 1 : 0);
      draw_hrun(cx - hw, cy + dy, 2 * hw + 1, c);
    end
  endfunction

  // Apply one command to the mirror and return the item it should produce.
  function automatic out_item_t rasterize(in_item_t it);
    out_item_t   res;
    int          x;
    int          y;
    int          sx;
    int          sy;
    int          r;
    logic [15:0] c;
    x   = int'(it.x_pos);
    y   = int'(it.y_pos);
    sx  = int'(it.second_x);
    sy  = int'(it.second_y);
    r   = int'(it.radius);
    c   = it.color;
    res = '0;
    case (it.kind)
      KIND_FILL:     foreach (frame_mirror[i]) frame_mirror[i] = c;
      KIND_PIXEL:    plot(x, y, c);
      KIND_HRUN:     draw_hrun(x, y, sx, c);
      KIND_VRUN:     draw_vrun(x, y, sy, c);
      KIND_LINE:     draw_line(x, y, sx, sy, c);
      KIND_RECT: begin
        draw_hrun(x, y, sx, c);
        draw_hrun(x, y + sy - 1, sx, c);
        draw_vrun(x, y, sy, c);
        draw_vrun(x + sx - 1, y, sy, c);
      end
      KIND_FILLRECT: for (int i = 0; i < sy; i++) draw_hrun(x, y + i, sx, c);
      KIND_CIRCLE:   draw_circle(x, y, r, c);
      KIND_FILLCIRC: draw_disc(x, y, r, c);
      KIND_READ: begin
        if (x >= 0 && x < FRAME_WIDTH && y >= 0 && y < FRAME_HEIGHT) begin
          res.read_color  = frame_mirror[y * FRAME_WIDTH + x];
          res.read_inside = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic in_item_t make_cmd(logic [3:0] k, int x, int y, int sx, int sy,
                                        int r, logic [15:0] c);
    in_item_t it;
    it.kind     = k;
    it.x_pos    = 12'(x);
    it.y_pos    = 12'(y);
    it.second_x = 12'(sx);
    it.second_y = 12'(sy);
    it.radius   = 12'(r);
    it.color    = c;
    return it;
  endfunction

  // Mostly near the frame, sometimes anywhere in the field's range.
  function automatic int pick_coord();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 85) return $urandom_range(0, 199) - 20;
    if (sel < 95) return int'($signed(12'($urandom)));
    case ($urandom_range(0, 5))
      0: return -2048;
      1: return 2047;
      2: return 0;
      3: return FRAME_WIDTH - 1;
      4: return FRAME_WIDTH;
      default: return -1;
    endcase
  endfunction

  function automatic int pick_size(int top);
    if ($urandom_range(0, 99) < 3) return -$urandom_range(1, 2048);
    return $urandom_range(0, top + 4) - 4;
  endfunction

  function automatic in_item_t random_cmd();
    in_item_t    it;
    int          sel;
    logic [3:0]  k;
    it       = make_cmd(KIND_PIXEL, pick_coord(), pick_coord(), 0, 0, 0, 16'($urandom));
    // unused fields carry noise so every bit toggles
    it.second_x = 12'($urandom);
    it.second_y = 12'($urandom);
    it.radius   = 12'($urandom);
    sel = $urandom_range(0, 999);
    if (sel < 3)        k = KIND_FILL;
    else if (sel < 300) k = KIND_READ;
    else if (sel < 330) k = 4'($urandom_range(10, 15));
    else                k = 4'($urandom_range(1, 8));
    it.kind = k;
    case (k)
      KIND_HRUN:     it.second_x = 12'(pick_size(180));
      KIND_VRUN:     it.second_y = 12'(pick_size(180));
      KIND_RECT: begin
        it.second_x = 12'(pick_size(180));
        it.second_y = 12'(pick_size(180));
      end
      KIND_FILLRECT: begin
        it.second_x = 12'(pick_size(80));
        it.second_y = 12'(pick_size(60));
      end
      KIND_LINE: begin
        it.second_x = 12'(pick_coord());
        it.second_y = 12'(pick_coord());
      end
      KIND_CIRCLE: if ($urandom_range(0, 99) >= 2) it.radius = 12'(pick_size(90));
      KIND_FILLCIRC: if ($urandom_range(0, 99) >= 1) it.radius = 12'(pick_size(70));
      default: ;
    endcase
    return it;
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push     <= 1'b0;
      in_item  <= '0;
      send_gap <= 0;
    end else begin
      if (push && !full) begin
        expected_results.push_back(rasterize(in_item));
        accepted++;
      end
      // hold the item while the queue is full
      if (!push || !full) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          push     <= 1'b0;
        end else if (accepted < total_planned - CALM_TAIL &&
                     $urandom_range(0, 19) == 0) begin
          send_gap <= $urandom_range(0, 14);
          push     <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          push    <= 1'b1;
          in_item <= pending_cmds.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop      <= 1'b0;
      take_gap <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result item: read_color %h read_inside %b",
                 out_item.read_color, out_item.read_inside);
          failures++;
        end else begin
          out_item_t want;
          want = expected_results.pop_front();
          checked++;
          if (out_item.read_inside) reads_inside++;
          if (out_item.read_color !== want.read_color) begin
            $error("read_color: expected %h, actual %h", want.read_color,
                   out_item.read_color);
            failures++;
          end
          if (out_item.read_inside !== want.read_inside) begin
            $error("read_inside: expected %b, actual %b", want.read_inside,
                   out_item.read_inside);
            failures++;
          end
        end
      end
      // stall the result side in bursts, never in the calm tail
      if (take_gap > 0) begin
        take_gap <= take_gap - 1;
        pop      <= 1'b0;
      end else if (accepted < total_planned - CALM_TAIL &&
                   $urandom_range(0, 19) == 0) begin
        take_gap <= $urandom_range(0, 14);
        pop      <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    failures      = 0;
    accepted      = 0;
    checked       = 0;
    reads_inside  = 0;
    cycles        = 0;
    total_planned = RANDOM_ITEMS + 100;
    foreach (frame_mirror[i]) frame_mirror[i] = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: check the cleared store, then every shape and its corner cases.
    pending_cmds.push_back(make_cmd(KIND_READ, 80, 80, 0, 0, 0, 16'h0));
    pending_cmds.push_back(make_cmd(KIND_FILL, 0, 0, 0, 0, 0, 16'hFFFF));
    pending_cmds.push_back(make_cmd(KIND_PIXEL, 0, 0, 0, 0, 0, 16'h0000));
    pending_cmds.push_back(make_cmd(KIND_PIXEL, 159, 159, 0, 0, 0, 16'h1234));
    pending_cmds.push_back(make_cmd(KIND_PIXEL, -1, 0, 0, 0, 0, 16'h5555));
    pending_cmds.push_back(make_cmd(KIND_PIXEL, 160, 5, 0, 0, 0, 16'hAAAA));
    pending_cmds.push_back(make_cmd(KIND_PIXEL, -2048, 2047, 0, 0, 0, 16'h8001));
    pending_cmds.push_back(make_cmd(KIND_HRUN, -10, 3, 200, 0, 0, 16'h0F0F));
    pending_cmds.push_back(make_cmd(KIND_HRUN, 5, 4, 0, 0, 0, 16'h0BAD));
    pending_cmds.push_back(make_cmd(KIND_VRUN, 7, -5, 0, -3, 0, 16'h0BAD));
    pending_cmds.push_back(make_cmd(KIND_VRUN, 7, 150, 0, 40, 0, 16'hF0F0));
    pending_cmds.push_back(make_cmd(KIND_LINE, -2048, -2048, 2047, 2047, 16'h07E0, 16'h07E0));
    pending_cmds.push_back(make_cmd(KIND_LINE, 150, 10, 20, 90, 0, 16'hF800));
    pending_cmds.push_back(make_cmd(KIND_RECT, 30, 30, 50, 20, 0, 16'h001F));
    pending_cmds.push_back(make_cmd(KIND_RECT, 30, 30, -1, 20, 0, 16'h7777));
    pending_cmds.push_back(make_cmd(KIND_FILLRECT, -2048, -2048, 2047, 2047, 0, 16'h3C3C));
    pending_cmds.push_back(make_cmd(KIND_FILLRECT, 100, 100, 30, 25, 0, 16'hC3C3));
    pending_cmds.push_back(make_cmd(KIND_CIRCLE, 80, 80, 0, 0, 40, 16'h1111));
    pending_cmds.push_back(make_cmd(KIND_CIRCLE, 80, 80, 0, 0, -3, 16'h2222));
    pending_cmds.push_back(make_cmd(KIND_FILLCIRC, 40, 120, 0, 0, 25, 16'h3333));
    pending_cmds.push_back(make_cmd(KIND_FILLCIRC, 40, 120, 0, 0, -5, 16'h4444));
    pending_cmds.push_back(make_cmd(KIND_FILLCIRC, 10, 10, 0, 0, 0, 16'h6666));
    pending_cmds.push_back(make_cmd(KIND_READ, 159, 159, 0, 0, 0, 16'h0));
    pending_cmds.push_back(make_cmd(KIND_READ, -2048, 2047, 0, 0, 0, 16'h0));
    pending_cmds.push_back(make_cmd(4'd15, 80, 80, 1, 1, 1, 16'hFFFF));

    // Pause the sender until the directed part has fully drained.
    wait (pending_cmds.size() == 0 && !push && expected_results.size() == 0);
    @(posedge clk_i);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pending_cmds.push_back(random_cmd());
      // follow some commands with a read of a random in-frame pixel
      if ($urandom_range(0, 3) == 0)
        pending_cmds.push_back(make_cmd(KIND_READ, $urandom_range(0, 159),
                                        $urandom_range(0, 159), 0, 0, 0, 16'h0));
    end
    total_planned = accepted + pending_cmds.size() + (push ? 1 : 0);

    wait (pending_cmds.size() == 0 && !push && expected_results.size() == 0);
    repeat (200) @(posedge clk_i);

    $display("Ran %0d commands over every shape, clipping and the unused kinds;",
             accepted);
    $display("checked %0d result items, %0d of them in-frame reads.", checked,
             reads_inside);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
